### rtl/core/stc_pkg.sv
// stc_pkg: types, character codes, token kinds and error codes for the source tokenizer
// no dependencies; imported by every module of the block

package stc_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLASH,
        ST_LINE_CMT,
        ST_BLOCK_CMT,
        ST_BLOCK_STAR,
        ST_COLON,
        ST_IDENT,
        ST_NUMBER,
        ST_STRING,
        ST_STRING_ESC,
        ST_CHAR_FIRST,
        ST_CHAR_ESC,
        ST_CHAR_CLOSE,
        ST_ERROR
    } scan_state_t;

    localparam logic [3:0] KIND_ERROR  = 4'd0;
    localparam logic [3:0] KIND_PLUS   = 4'd0;
    localparam logic [3:0] KIND_MINUS  = 4'd1;
    localparam logic [3:0] KIND_STAR   = 4'd2;
    localparam logic [3:0] KIND_SLASH  = 4'd3;
    localparam logic [3:0] KIND_SEMI   = 4'd4;
    localparam logic [3:0] KIND_EQUAL  = 4'd5;
    localparam logic [3:0] KIND_LPAREN = 4'd6;
    localparam logic [3:0] KIND_RPAREN = 4'd7;
    localparam logic [3:0] KIND_LBRACE = 4'd8;
    localparam logic [3:0] KIND_RBRACE = 4'd9;
    localparam logic [3:0] KIND_DCOLON = 4'd10;
    localparam logic [3:0] KIND_IDENT  = 4'd11;
    localparam logic [3:0] KIND_INT    = 4'd12;
    localparam logic [3:0] KIND_STRING = 4'd13;
    localparam logic [3:0] KIND_CHAR   = 4'd14;
    localparam logic [3:0] KIND_EOF    = 4'd15;

    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_OPEN_COMMENT  = 3'd1;
    localparam logic [2:0] ERR_UNRECOGNISED  = 3'd2;
    localparam logic [2:0] ERR_OPEN_STRING   = 3'd3;
    localparam logic [2:0] ERR_BAD_CHAR_LIT  = 3'd4;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_EQUAL  = 8'h3d;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    // result queue depth in tokens: a word is decoded only while two slots are free
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [7:0]  char_value;
        logic [2:0]  error_code;
        logic        last_result;
    } token_t;

    // up to two tokens produced by one input word
    typedef struct packed {
        logic [1:0] cnt;
        token_t     first;
        token_t     second;
    } push_t;

    function automatic token_t make_token(input logic [3:0] kind, input logic [15:0] start,
                                          input logic [15:0] len, input logic [7:0] value,
                                          input logic [2:0] err);
        token_t t;
        t.token_kind   = kind;
        t.token_start  = start;
        t.token_length = len;
        t.char_value   = value;
        t.error_code   = err;
        t.last_result  = 1'b0;
        return t;
    endfunction

    function automatic push_t push_token(input push_t p, input token_t t);
        push_t q;
        q = p;
        case (p.cnt)
            2'd0:    q.first = t;
            2'd1:    q.second = t;
            default: ;
        endcase
        if (p.cnt != 2'd2)
            q.cnt = p.cnt + 2'd1;
        return q;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

endpackage

### rtl/core/stc_if.sv
// stc_if: handshake channels of the tokenizer, one for source characters, one for tokens
// no dependencies

interface stc_char_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] char_byte;

    modport source (output valid, mode, char_byte, input ready);
    modport sink   (input valid, mode, char_byte, output ready);
endinterface

interface stc_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [7:0]  char_value;
    logic [2:0]  error_code;
    logic        last_result;

    modport source  (output valid, token_kind, token_start, token_length, char_value,
                     error_code, last_result, input ready);
    modport sink    (input valid, token_kind, token_start, token_length, char_value,
                     error_code, last_result, output ready);
    modport monitor (input valid, ready, token_kind, token_start, token_length, char_value,
                     error_code, last_result);
endinterface

### rtl/core/stc_lex.sv
// stc_lex: scanner state registers and the single-pass decode of one word into tokens
// depends on stc_pkg

module stc_lex #(
    parameter int OFFSET_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  logic           mode,
    input  logic [7:0]     char_byte,
    output stc_pkg::push_t push
);
    import stc_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] OFFSET_ONE = OFFSET_BITS'(1);

    scan_state_t             state_reg, state_next;
    logic [OFFSET_BITS-1:0]  pos_reg, pos_next;
    logic [OFFSET_BITS-1:0]  start_reg, start_next;
    logic [7:0]              lit_reg, lit_next;

    logic [OFFSET_BITS-1:0]  pos_inc;
    logic [15:0]             pos16, start16, span_cur16, span_inc16;
    scan_state_t             idle_state;
    logic                    idle_hit;
    token_t                  idle_tok;
    logic                    take_idle;
    push_t                   p;

    function automatic logic [15:0] to16(input logic [OFFSET_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    assign pos_inc    = (pos_reg == OFFSET_MAX) ? pos_reg : pos_reg + OFFSET_ONE;
    assign pos16      = to16(pos_reg);
    assign start16    = to16(start_reg);
    assign span_cur16 = to16((pos_reg >= start_reg) ? pos_reg - start_reg : '0);
    assign span_inc16 = to16((pos_inc >= start_reg) ? pos_inc - start_reg : '0);

    // what a character does when no lexeme is open
    always_comb
    begin
        idle_state = ST_IDLE;
        idle_hit   = 1'b0;
        idle_tok   = make_token(KIND_PLUS, pos16, 16'd1, 8'd0, ERR_NONE);
        case (char_byte)
            CH_SPACE, CH_TAB, CH_LF, CH_CR: idle_state = ST_IDLE;
            CH_SLASH:  idle_state = ST_SLASH;
            CH_SQUOTE: idle_state = ST_CHAR_FIRST;
            CH_DQUOTE: idle_state = ST_STRING;
            CH_COLON:  idle_state = ST_COLON;
            CH_PLUS:   idle_hit = 1'b1;
            CH_MINUS:
            begin
                idle_hit = 1'b1;
                idle_tok.token_kind = KIND_MINUS;
            end
            CH_STAR:
            begin
                idle_hit = 1'b1;
                idle_tok.token_kind = KIND_STAR;
            end
            CH_SEMI:
            begin
                idle_hit = 1'b1;
                idle_tok.token_kind = KIND_SEMI;
            end
            CH_EQUAL:
            begin
                idle_hit = 1'b1;
                idle_tok.token_kind = KIND_EQUAL;
            end
            CH_LPAREN:
            begin
                idle_hit = 1'b1;
                idle_tok.token_kind = KIND_LPAREN;
            end
            CH_RPAREN:
            begin
                idle_hit = 1'b1;
                idle_tok.token_kind = KIND_RPAREN;
            end
            CH_LBRACE:
            begin
                idle_hit = 1'b1;
                idle_tok.token_kind = KIND_LBRACE;
            end
            CH_RBRACE:
            begin
                idle_hit = 1'b1;
                idle_tok.token_kind = KIND_RBRACE;
            end
            default:
            begin
                if (is_alpha(char_byte))
                    idle_state = ST_IDENT;
                else if (is_digit(char_byte))
                    idle_state = ST_NUMBER;
                else
                begin
                    idle_state = ST_ERROR;
                    idle_hit   = 1'b1;
                    idle_tok   = make_token(KIND_ERROR, pos16, 16'd0, 8'd0, ERR_UNRECOGNISED);
                end
            end
        endcase
    end

    always_comb
    begin
        p          = '0;
        state_next = state_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        lit_next   = lit_reg;
        take_idle  = 1'b0;
        if (mode)
        begin
            // flush whatever is open, then the end-of-text token
            case (state_reg)
                ST_SLASH:
                    p = push_token(p, make_token(KIND_SLASH, start16, 16'd1, 8'd0, ERR_NONE));
                ST_BLOCK_CMT, ST_BLOCK_STAR:
                    p = push_token(p, make_token(KIND_ERROR, start16, 16'd0, 8'd0,
                                                 ERR_OPEN_COMMENT));
                ST_COLON:
                    p = push_token(p, make_token(KIND_ERROR, start16, 16'd0, 8'd0,
                                                 ERR_UNRECOGNISED));
                ST_IDENT:
                    p = push_token(p, make_token(KIND_IDENT, start16, span_cur16, 8'd0,
                                                 ERR_NONE));
                ST_NUMBER:
                    p = push_token(p, make_token(KIND_INT, start16, span_cur16, 8'd0,
                                                 ERR_NONE));
                ST_STRING, ST_STRING_ESC:
                    p = push_token(p, make_token(KIND_ERROR, start16, 16'd0, 8'd0,
                                                 ERR_OPEN_STRING));
                ST_CHAR_FIRST, ST_CHAR_ESC, ST_CHAR_CLOSE:
                    p = push_token(p, make_token(KIND_ERROR, start16, 16'd0, 8'd0,
                                                 ERR_BAD_CHAR_LIT));
                default: ;
            endcase
            p = push_token(p, make_token(KIND_EOF, pos16, 16'd0, 8'd0, ERR_NONE));
            state_next = ST_IDLE;
            pos_next   = '0;
            start_next = '0;
            lit_next   = 8'd0;
        end
        else
        begin
            pos_next = pos_inc;
            case (state_reg)
                ST_IDLE: take_idle = 1'b1;
                ST_SLASH:
                begin
                    if (char_byte == CH_SLASH)
                        state_next = ST_LINE_CMT;
                    else if (char_byte == CH_STAR)
                        state_next = ST_BLOCK_CMT;
                    else
                    begin
                        p = push_token(p, make_token(KIND_SLASH, start16, 16'd1, 8'd0,
                                                     ERR_NONE));
                        take_idle = 1'b1;
                    end
                end
                ST_LINE_CMT:
                    if (char_byte == CH_LF)
                        state_next = ST_IDLE;
                ST_BLOCK_CMT:
                    if (char_byte == CH_STAR)
                        state_next = ST_BLOCK_STAR;
                ST_BLOCK_STAR:
                begin
                    if (char_byte == CH_SLASH)
                        state_next = ST_IDLE;
                    else if (char_byte != CH_STAR)
                        state_next = ST_BLOCK_CMT;
                end
                ST_COLON:
                begin
                    if (char_byte == CH_COLON)
                    begin
                        p = push_token(p, make_token(KIND_DCOLON, start16, span_inc16, 8'd0,
                                                     ERR_NONE));
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // lone colon: the byte after it and every later byte up to the end marker are swallowed
                        p = push_token(p, make_token(KIND_ERROR, start16, 16'd0, 8'd0,
                                                     ERR_UNRECOGNISED));
                        state_next = ST_ERROR;
                    end
                end
                ST_IDENT, ST_NUMBER:
                begin
                    if (!(is_digit(char_byte) ||
                          (state_reg == ST_IDENT && is_alpha(char_byte))))
                    begin
                        p = push_token(p, make_token((state_reg == ST_IDENT) ? KIND_IDENT
                                                                             : KIND_INT,
                                                     start16, span_cur16, 8'd0, ERR_NONE));
                        take_idle = 1'b1;
                    end
                end
                ST_STRING:
                begin
                    if (char_byte == CH_DQUOTE)
                    begin
                        p = push_token(p, make_token(KIND_STRING, start16, span_inc16, 8'd0,
                                                     ERR_NONE));
                        state_next = ST_IDLE;
                    end
                    else if (char_byte == CH_BSLASH)
                        state_next = ST_STRING_ESC;
                end
                ST_STRING_ESC: state_next = ST_STRING;
                ST_CHAR_FIRST:
                begin
                    if (char_byte == CH_BSLASH)
                        state_next = ST_CHAR_ESC;
                    else
                    begin
                        lit_next   = char_byte;
                        state_next = ST_CHAR_CLOSE;
                    end
                end
                ST_CHAR_ESC:
                begin
                    lit_next   = char_byte;
                    state_next = ST_CHAR_CLOSE;
                end
                ST_CHAR_CLOSE:
                begin
                    if (char_byte == CH_SQUOTE)
                    begin
                        p = push_token(p, make_token(KIND_CHAR, start16, span_inc16, lit_reg,
                                                     ERR_NONE));
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        p = push_token(p, make_token(KIND_ERROR, start16, 16'd0, 8'd0,
                                                     ERR_BAD_CHAR_LIT));
                        state_next = ST_ERROR;
                    end
                end
                default: ;
            endcase
            if (take_idle)
            begin
                state_next = idle_state;
                start_next = pos_reg;
                if (idle_hit)
                    p = push_token(p, idle_tok);
            end
        end
        case (p.cnt)
            2'd1:    p.first.last_result = 1'b1;
            2'd2:    p.second.last_result = 1'b1;
            default: ;
        endcase
    end

    assign push = p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            lit_reg   <= 8'd0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            lit_reg   <= lit_next;
        end
    end

endmodule

### rtl/core/stc_oq.sv
// stc_oq: small result queue taking up to two tokens a cycle, giving one a cycle while the sink is ready
// depends on stc_pkg

module stc_oq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_en,
    input  stc_pkg::push_t  push,
    output logic            room,
    output logic            head_valid,
    input  logic            head_ready,
    output stc_pkg::token_t head
);
    import stc_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    token_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_reg, wr_next, rd_reg, rd_next, wr_plus1;
    logic [PTR_BITS:0]   count_reg, count_next;
    logic [1:0]          n_in;
    logic                pop;

    assign n_in       = push_en ? push.cnt : 2'd0;
    assign head_valid = count_reg != '0;
    assign pop        = head_valid && head_ready;
    assign head       = slot_reg[rd_reg];
    assign wr_plus1   = wr_reg + PTR_BITS'(1);
    assign wr_next    = wr_reg + PTR_BITS'(n_in);
    assign rd_next    = rd_reg + PTR_BITS'(pop);
    assign count_next = count_reg + (PTR_BITS+1)'(n_in) - (PTR_BITS+1)'(pop);
    // two free slots needed before the next word is decoded
    assign room       = count_reg <= (PTR_BITS+1)'(QUEUE_DEPTH - 2);

    always_ff @(posedge clk)
    begin
        if (n_in != 2'd0)
            slot_reg[wr_reg] <= push.first;
        if (n_in == 2'd2)
            slot_reg[wr_plus1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/core/source_char_tokenizer.sv
// source_char_tokenizer: top level, input stage, scanner and result queue
// depends on stc_pkg, stc_if, stc_lex, stc_oq

// Takes one source character (or an end-of-text marker) per word and returns tokens with
// kind, start offset, length, character-literal value and error code. A word is accepted
// every cycle while the queue has room; it is registered in the input stage, decoded there
// in a single pass, and its tokens are registered in a four-entry queue.
// A word that ends a lexeme and starts or is another token gives two tokens, as does an
// end marker that closes an open lexeme; the queue absorbs these, and input stalls only
// when the queue holds more than two tokens. No clearing pass after reset.

module source_char_tokenizer #(
    parameter int OFFSET_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    stc_char_if.sink     chars,
    stc_token_if.source  tokens
);
    import stc_pkg::*;

    logic       stage_vld_reg, stage_vld_next;
    logic       stage_mode_reg;
    logic [7:0] stage_byte_reg;
    logic       fire;
    logic       room;
    push_t      push;
    token_t     head;

    assign fire           = stage_vld_reg && room;
    assign chars.ready    = !stage_vld_reg || fire;
    assign stage_vld_next = (chars.valid && chars.ready) || (stage_vld_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_vld_reg <= 1'b0;
        else
            stage_vld_reg <= stage_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            stage_mode_reg <= chars.mode;
            stage_byte_reg <= chars.char_byte;
        end
    end

    stc_lex #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_lex (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .mode      (stage_mode_reg),
        .char_byte (stage_byte_reg),
        .push      (push)
    );

    stc_oq u_oq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (fire),
        .push       (push),
        .room       (room),
        .head_valid (tokens.valid),
        .head_ready (tokens.ready),
        .head       (head)
    );

    assign tokens.token_kind   = head.token_kind;
    assign tokens.token_start  = head.token_start;
    assign tokens.token_length = head.token_length;
    assign tokens.char_value   = head.char_value;
    assign tokens.error_code   = head.error_code;
    assign tokens.last_result  = head.last_result;

endmodule

### rtl/core/stc_checker.sv
// stc_checker: assertions on the token port of the tokenizer, bound to the top level
// depends on stc_pkg; the bind reaches the top level's token interface port

module stc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic [3:0]  token_kind,
    input logic [15:0] token_start,
    input logic [15:0] token_length,
    input logic [7:0]  char_value,
    input logic [2:0]  error_code,
    input logic        last_result
);
    import stc_pkg::*;

    // a stalled word stays offered
    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("token valid dropped while stalled");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> $stable(token_kind) &&
            $stable(token_start) && $stable(token_length) &&
            $stable(last_result))
        else $error("token payload changed while stalled");

    // end of text always closes the word's results
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && token_kind == KIND_EOF && error_code == ERR_NONE
            |-> last_result)
        else $error("eof token not marked last");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        valid && error_code != ERR_NONE
            |-> token_kind == KIND_ERROR && token_length == 16'd0 &&
                char_value == 8'd0)
        else $error("error word carries token fields");

    a_value_only_char: assert property (@(posedge clk) disable iff (!rst_n)
        valid && char_value != 8'd0 |-> token_kind == KIND_CHAR)
        else $error("character value on a non-character token");

endmodule

bind source_char_tokenizer stc_checker u_stc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (tokens.valid),
    .ready        (tokens.ready),
    .token_kind   (tokens.token_kind),
    .token_start  (tokens.token_start),
    .token_length (tokens.token_length),
    .char_value   (tokens.char_value),
    .error_code   (tokens.error_code),
    .last_result  (tokens.last_result)
);

### bench/testbench.sv
// testbench: self-checking bench for source_char_tokenizer, directed table then random texts
// depends on stc_pkg, stc_if and the tokenizer RTL; token stream checked against a local scanner

module testbench;
    import stc_pkg::*;

    localparam int          OFFSET_BITS  = 16;
    localparam int unsigned POS_MAX      = (1 << OFFSET_BITS) - 1;
    localparam int          RANDOM_WORDS = 800;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic       mode;
        logic [7:0] c;
        logic       known;
        token_t     want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    stc_char_if  chars_if ();
    stc_token_if tokens_if ();

    source_char_tokenizer #(
        .OFFSET_BITS (OFFSET_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .tokens (tokens_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // scanner state of the bench
    scan_state_t scan = ST_IDLE;
    int unsigned pos = 0;
    int unsigned lex_start = 0;
    logic [7:0]  lit_char = 8'h00;
    token_t      fresh[$];
    token_t      awaited_tokens[$];

    int  cycle_count = 0;
    int  mismatch_count = 0;
    int  tokens_checked = 0;
    int  error_tokens = 0;
    int  words_sent = 0;
    int  live_words = 0;
    int  texts_sent = 0;
    int  gap_ahead = 0;
    int  calm_source = 0;
    int  calm_sink = 0;
    stim_row_t plan[$];

    function automatic token_t tok(input logic [3:0] kind, input int unsigned start,
                                   input int unsigned len, input logic [7:0] value,
                                   input logic [2:0] err);
        token_t t;
        t.token_kind   = kind;
        t.token_start  = start[15:0];
        t.token_length = len[15:0];
        t.char_value   = value;
        t.error_code   = err;
        t.last_result  = 1'b0;
        return t;
    endfunction

    function automatic stim_row_t row(input logic m, input logic [7:0] c);
        stim_row_t r;
        r = '0;
        r.mode = m;
        r.c = c;
        return r;
    endfunction

    function automatic stim_row_t row_known(input logic m, input logic [7:0] c, input token_t t);
        stim_row_t r;
        r = row(m, c);
        r.known = 1'b1;
        r.want = t;
        return r;
    endfunction

    // 0-9 digits, 10-35 upper case, 36-61 lower case
    function automatic logic [7:0] alnum(input int k);
        if (k < 10)
            return 8'h30 + k[7:0];
        else if (k < 36)
            return 8'h41 + k[7:0] - 8'd10;
        return 8'h61 + k[7:0] - 8'd36;
    endfunction

    function automatic logic [7:0] blank(input int k);
        case (k)
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function automatic bit is_numeral(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            calm = $urandom_range(10, 80);
            return 0;
        end
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic void emit(input logic [3:0] kind, input int unsigned start,
                                 input int unsigned len, input logic [7:0] value,
                                 input logic [2:0] err);
        if (fresh.size() < 2)
            fresh = {fresh, tok(kind, start, len, value, err)};
    endfunction

    function automatic void raise_error(input int unsigned start, input logic [2:0] code);
        emit(KIND_ERROR, start, 0, 8'h00, code);
        scan = ST_ERROR;
    endfunction

    // lexeme length up to an end offset, clamped with the saturated position
    function automatic int unsigned span_to(input int unsigned stop);
        if (stop > POS_MAX)
            stop = POS_MAX;
        return (stop >= lex_start) ? stop - lex_start : 0;
    endfunction

    function automatic void start_lexeme(input logic [7:0] c);
        lex_start = pos;
        case (c)
            CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
            CH_SLASH:  scan = ST_SLASH;
            CH_SQUOTE: scan = ST_CHAR_FIRST;
            CH_DQUOTE: scan = ST_STRING;
            CH_COLON:  scan = ST_COLON;
            CH_PLUS:   emit(KIND_PLUS, pos, 1, 8'h00, ERR_NONE);
            CH_MINUS:  emit(KIND_MINUS, pos, 1, 8'h00, ERR_NONE);
            CH_STAR:   emit(KIND_STAR, pos, 1, 8'h00, ERR_NONE);
            CH_SEMI:   emit(KIND_SEMI, pos, 1, 8'h00, ERR_NONE);
            CH_EQUAL:  emit(KIND_EQUAL, pos, 1, 8'h00, ERR_NONE);
            CH_LPAREN: emit(KIND_LPAREN, pos, 1, 8'h00, ERR_NONE);
            CH_RPAREN: emit(KIND_RPAREN, pos, 1, 8'h00, ERR_NONE);
            CH_LBRACE: emit(KIND_LBRACE, pos, 1, 8'h00, ERR_NONE);
            CH_RBRACE: emit(KIND_RBRACE, pos, 1, 8'h00, ERR_NONE);
            default:
            begin
                if (is_letter(c))
                    scan = ST_IDENT;
                else if (is_numeral(c))
                    scan = ST_NUMBER;
                else
                    raise_error(pos, ERR_UNRECOGNISED);
            end
        endcase
    endfunction

    // tokens that one accepted word gives, left in fresh
    function automatic void tokenize_word(input logic m, input logic [7:0] c);
        fresh.delete();
        if (m || scan != ST_ERROR)
            live_words++;
        if (m)
        begin
            case (scan)
                ST_SLASH:      emit(KIND_SLASH, lex_start, 1, 8'h00, ERR_NONE);
                ST_BLOCK_CMT, ST_BLOCK_STAR:
                    emit(KIND_ERROR, lex_start, 0, 8'h00, ERR_OPEN_COMMENT);
                ST_COLON:      emit(KIND_ERROR, lex_start, 0, 8'h00, ERR_UNRECOGNISED);
                ST_IDENT:      emit(KIND_IDENT, lex_start, span_to(pos), 8'h00, ERR_NONE);
                ST_NUMBER:     emit(KIND_INT, lex_start, span_to(pos), 8'h00, ERR_NONE);
                ST_STRING, ST_STRING_ESC:
                    emit(KIND_ERROR, lex_start, 0, 8'h00, ERR_OPEN_STRING);
                ST_CHAR_FIRST, ST_CHAR_ESC, ST_CHAR_CLOSE:
                    emit(KIND_ERROR, lex_start, 0, 8'h00, ERR_BAD_CHAR_LIT);
                default: ;
            endcase
            emit(KIND_EOF, pos, 0, 8'h00, ERR_NONE);
            scan = ST_IDLE;
            pos = 0;
            lex_start = 0;
            lit_char = 8'h00;
        end
        else
        begin
            case (scan)
                ST_IDLE: start_lexeme(c);
                ST_SLASH:
                begin
                    if (c == CH_SLASH)
                        scan = ST_LINE_CMT;
                    else if (c == CH_STAR)
                        scan = ST_BLOCK_CMT;
                    else
                    begin
                        emit(KIND_SLASH, lex_start, 1, 8'h00, ERR_NONE);
                        scan = ST_IDLE;
                        start_lexeme(c);
                    end
                end
                ST_LINE_CMT:
                    if (c == CH_LF)
                        scan = ST_IDLE;
                ST_BLOCK_CMT:
                    if (c == CH_STAR)
                        scan = ST_BLOCK_STAR;
                ST_BLOCK_STAR:
                begin
                    if (c == CH_SLASH)
                        scan = ST_IDLE;
                    else if (c != CH_STAR)
                        scan = ST_BLOCK_CMT;
                end
                ST_COLON:
                begin
                    if (c == CH_COLON)
                    begin
                        emit(KIND_DCOLON, lex_start, span_to(pos + 1), 8'h00, ERR_NONE);
                        scan = ST_IDLE;
                    end
                    else
                        raise_error(lex_start, ERR_UNRECOGNISED);
                end
                ST_IDENT, ST_NUMBER:
                begin
                    if (!(is_numeral(c) || (scan == ST_IDENT && is_letter(c))))
                    begin
                        emit((scan == ST_IDENT) ? KIND_IDENT : KIND_INT, lex_start,
                             span_to(pos), 8'h00, ERR_NONE);
                        scan = ST_IDLE;
                        start_lexeme(c);
                    end
                end
                ST_STRING:
                begin
                    if (c == CH_DQUOTE)
                    begin
                        emit(KIND_STRING, lex_start, span_to(pos + 1), 8'h00, ERR_NONE);
                        scan = ST_IDLE;
                    end
                    else if (c == CH_BSLASH)
                        scan = ST_STRING_ESC;
                end
                ST_STRING_ESC: scan = ST_STRING;
                ST_CHAR_FIRST:
                begin
                    if (c == CH_BSLASH)
                        scan = ST_CHAR_ESC;
                    else
                    begin
                        lit_char = c;
                        scan = ST_CHAR_CLOSE;
                    end
                end
                ST_CHAR_ESC:
                begin
                    lit_char = c;
                    scan = ST_CHAR_CLOSE;
                end
                ST_CHAR_CLOSE:
                begin
                    if (c == CH_SQUOTE)
                    begin
                        emit(KIND_CHAR, lex_start, span_to(pos + 1), lit_char, ERR_NONE);
                        scan = ST_IDLE;
                    end
                    else
                        raise_error(lex_start, ERR_BAD_CHAR_LIT);
                end
                default: ;
            endcase
            if (pos < POS_MAX)
                pos++;
        end
        if (fresh.size() > 0)
            fresh[fresh.size() - 1].last_result = 1'b1;
    endfunction

    task automatic send_word(input stim_row_t w);
        token_t t;
        repeat (gap_ahead) @(posedge clk);
        chars_if.valid     <= 1'b1;
        chars_if.mode      <= w.mode;
        chars_if.char_byte <= w.c;
        do
            @(posedge clk);
        while (chars_if.ready !== 1'b1);
        tokenize_word(w.mode, w.c);
        if (w.known)
        begin
            t = w.want;
            t.last_result = 1'b1;
            awaited_tokens = {awaited_tokens, t};
        end
        else
            foreach (fresh[i])
                awaited_tokens = {awaited_tokens, fresh[i]};
        words_sent++;
        if (w.mode)
            texts_sent++;
        gap_ahead = draw_wait(calm_source);
        if (gap_ahead > 0)
            chars_if.valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        // valid is still up from the last word unless a gap was drawn after it
        if (gap_ahead == 0)
            chars_if.valid <= 1'b0;
        while (awaited_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input token_t want, input token_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%s at cycle %0d", what, cycle_count);
            $display("  expected kind %0d start %0d len %0d value %02h err %0d last %0b",
                     want.token_kind, want.token_start, want.token_length, want.char_value,
                     want.error_code, want.last_result);
            $display("  actual   kind %0d start %0d len %0d value %02h err %0d last %0b",
                     got.token_kind, got.token_start, got.token_length, got.char_value,
                     got.error_code, got.last_result);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("source_char_tokenizer verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin : token_check
        token_t got;
        token_t want;
        if (rst_n === 1'b1 && tokens_if.valid === 1'b1 && tokens_if.ready === 1'b1)
        begin
            got.token_kind   = tokens_if.token_kind;
            got.token_start  = tokens_if.token_start;
            got.token_length = tokens_if.token_length;
            got.char_value   = tokens_if.char_value;
            got.error_code   = tokens_if.error_code;
            got.last_result  = tokens_if.last_result;
            tokens_checked++;
            if (got.error_code != ERR_NONE)
                error_tokens++;
            if (awaited_tokens.size() == 0)
                report_mismatch("unexpected token", '0, got);
            else
            begin
                want = awaited_tokens.pop_front();
                if (got !== want)
                    report_mismatch("token mismatch", want, got);
            end
        end
    end

    // token side back-pressure, one draw per token taken
    initial
    begin : sink_pacing
        int stall;
        tokens_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait(calm_sink);
            if (stall > 0)
            begin
                tokens_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            tokens_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (tokens_if.valid !== 1'b1);
        end
    end

    initial
    begin : stimulus
        logic [7:0] text[$];
        logic [7:0] b;
        int         pieces;
        int         sent_before;

        chars_if.valid     = 1'b0;
        chars_if.mode      = 1'b0;
        chars_if.char_byte = 8'h00;
        rst_n              = 1'b0;

        // every single-character operator but the slash, from offset zero
        plan = {plan, row_known(1'b0, CH_PLUS, tok(KIND_PLUS, 0, 1, 8'h00, ERR_NONE))};
        plan = {plan, row_known(1'b0, CH_MINUS, tok(KIND_MINUS, 1, 1, 8'h00, ERR_NONE))};
        plan = {plan, row_known(1'b0, CH_STAR, tok(KIND_STAR, 2, 1, 8'h00, ERR_NONE))};
        plan = {plan, row_known(1'b0, CH_SEMI, tok(KIND_SEMI, 3, 1, 8'h00, ERR_NONE))};
        plan = {plan, row_known(1'b0, CH_EQUAL, tok(KIND_EQUAL, 4, 1, 8'h00, ERR_NONE))};
        plan = {plan, row_known(1'b0, CH_LPAREN, tok(KIND_LPAREN, 5, 1, 8'h00, ERR_NONE))};
        plan = {plan, row_known(1'b0, CH_RPAREN, tok(KIND_RPAREN, 6, 1, 8'h00, ERR_NONE))};
        plan = {plan, row_known(1'b0, CH_LBRACE, tok(KIND_LBRACE, 7, 1, 8'h00, ERR_NONE))};
        plan = {plan, row_known(1'b0, CH_RBRACE, tok(KIND_RBRACE, 8, 1, 8'h00, ERR_NONE))};
        // identifier ended by a slash that opens an empty block comment
        plan = {plan, row(1'b0, 8'h5a)};
        plan = {plan, row(1'b0, 8'h30)};
        plan = {plan, row(1'b0, CH_SLASH)};
        plan = {plan, row(1'b0, CH_STAR)};
        plan = {plan, row(1'b0, CH_STAR)};
        plan = {plan, row(1'b0, CH_SLASH)};
        // the digit right after the comment must not be swallowed
        plan = {plan, row(1'b0, 8'h37)};
        plan = {plan, row(1'b0, CH_COLON)};
        plan = {plan, row(1'b0, CH_COLON)};
        // escaped quote as a character literal
        plan = {plan, row(1'b0, CH_SQUOTE)};
        plan = {plan, row(1'b0, CH_BSLASH)};
        plan = {plan, row(1'b0, CH_SQUOTE)};
        plan = {plan, row(1'b0, CH_SQUOTE)};
        // string left open at the end marker
        plan = {plan, row(1'b0, CH_DQUOTE)};
        plan = {plan, row(1'b0, 8'h78)};
        plan = {plan, row(1'b1, 8'h00)};
        // non-ascii byte, then everything ignored up to the end marker
        plan = {plan, row_known(1'b0, 8'h80, tok(KIND_ERROR, 0, 0, 8'h00, ERR_UNRECOGNISED))};
        plan = {plan, row(1'b0, 8'hff)};
        plan = {plan, row_known(1'b1, 8'h00, tok(KIND_EOF, 2, 0, 8'h00, ERR_NONE))};
        // lone colon
        plan = {plan, row(1'b0, CH_COLON)};
        plan = {plan, row_known(1'b0, 8'h71, tok(KIND_ERROR, 0, 0, 8'h00, ERR_UNRECOGNISED))};
        plan = {plan, row_known(1'b1, 8'h00, tok(KIND_EOF, 2, 0, 8'h00, ERR_NONE))};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_word(plan[i]);
        wait_for_drain();

        sent_before = words_sent;
        while (words_sent - sent_before < RANDOM_WORDS)
        begin
            text.delete();
            pieces = $urandom_range(1, 16);
            repeat (pieces)
            begin
                case ($urandom_range(0, 11))
                    0, 1:
                    begin
                        case ($urandom_range(0, 9))
                            0:       b = CH_PLUS;
                            1:       b = CH_MINUS;
                            2:       b = CH_STAR;
                            3:       b = CH_SEMI;
                            4:       b = CH_EQUAL;
                            5:       b = CH_LPAREN;
                            6:       b = CH_RPAREN;
                            7:       b = CH_LBRACE;
                            8:       b = CH_RBRACE;
                            default: b = CH_SLASH;
                        endcase
                        text = {text, b};
                    end
                    2, 3:
                    begin
                        text = {text, alnum($urandom_range(10, 61))};
                        repeat ($urandom_range(0, 6))
                            text = {text, alnum($urandom_range(0, 61))};
                    end
                    4:
                        repeat ($urandom_range(1, 5))
                            text = {text, alnum($urandom_range(0, 9))};
                    5:
                    begin
                        text = {text, CH_DQUOTE};
                        repeat ($urandom_range(0, 5))
                        begin
                            b = 8'($urandom_range(0, 255));
                            if ($urandom_range(0, 3) == 0)
                            begin
                                text = {text, CH_BSLASH};
                                if ($urandom_range(0, 1) == 0)
                                    b = CH_DQUOTE;
                            end
                            else if (b == CH_DQUOTE || b == CH_BSLASH)
                                b = CH_SPACE;
                            text = {text, b};
                        end
                        text = {text, CH_DQUOTE};
                    end
                    6:
                    begin
                        text = {text, CH_SQUOTE};
                        if ($urandom_range(0, 2) == 0)
                            text = {text, CH_BSLASH};
                        b = 8'($urandom_range(0, 255));
                        text = {text, b};
                        // an extra character makes a bad literal
                        if ($urandom_range(0, 5) == 0)
                            text = {text, alnum($urandom_range(0, 61))};
                        text = {text, CH_SQUOTE};
                    end
                    7:
                    begin
                        text = {text, CH_SLASH};
                        text = {text, CH_SLASH};
                        repeat ($urandom_range(0, 6))
                        begin
                            b = 8'($urandom_range(0, 255));
                            if (b == CH_LF)
                                b = CH_SPACE;
                            text = {text, b};
                        end
                        text = {text, CH_LF};
                    end
                    8:
                    begin
                        text = {text, CH_SLASH};
                        text = {text, CH_STAR};
                        repeat ($urandom_range(0, 6))
                        begin
                            b = 8'($urandom_range(0, 255));
                            if ($urandom_range(0, 2) == 0)
                                b = CH_STAR;
                            text = {text, b};
                        end
                        text = {text, CH_STAR};
                        text = {text, CH_SLASH};
                    end
                    9:
                    begin
                        text = {text, CH_COLON};
                        if ($urandom_range(0, 3) != 0)
                            text = {text, CH_COLON};
                    end
                    10:
                        text = {text, blank($urandom_range(0, 3))};
                    default:
                    begin
                        b = 8'($urandom_range(0, 255));
                        text = {text, b};
                    end
                endcase
                if ($urandom_range(0, 1) == 0)
                    text = {text, blank($urandom_range(0, 3))};
            end
            // cut some texts short so that lexemes are still open at the end marker
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 3))
                    if (text.size() > 0)
                        void'(text.pop_back());
            end
            foreach (text[i])
                send_word(row(1'b0, text[i]));
            b = 8'($urandom_range(0, 255));
            send_word(row(1'b1, b));
            if (texts_sent % 8 == 0)
                wait_for_drain();
        end

        wait_for_drain();

        $display("%0d texts, %0d words sent (%0d not ignored), %0d tokens checked",
                 texts_sent, words_sent, live_words, tokens_checked);
        $display("%0d error tokens seen, lexemes left open at the end marker included",
                 error_tokens);
        if (mismatch_count == 0)
            $display("source_char_tokenizer verification clean");
        else
            $display("source_char_tokenizer verification failed");
        $finish;
    end

endmodule
